// File: hw/rtl/tqm_pkg.sv
// Shared constants, codes and types of the team queue manager.
package tqm_pkg;

    localparam int MEMBER_W        = 10;
    localparam int TEAM_W          = 4;
    localparam int NUM_TEAMS       = 1 << TEAM_W;
    localparam int MEMBER_ID_SPACE = 1 << MEMBER_W;
    localparam int PTR_W           = 6;
    localparam int TEAM_FIFO_DEPTH = 1 << PTR_W;
    localparam int CNT_W           = PTR_W + 1;
    localparam int ORD_CNT_W       = TEAM_W + 1;
    localparam int STORE_AW        = TEAM_W + PTR_W;
    localparam int STORE_DEPTH     = 1 << STORE_AW;

    localparam logic [1:0] MODE_ASSIGN  = 2'd0;
    localparam logic [1:0] MODE_ENQUEUE = 2'd1;
    localparam logic [1:0] MODE_DEQUEUE = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_POPPED = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef logic [MEMBER_W-1:0] member_t;
    typedef logic [TEAM_W-1:0]   team_t;

    // Requests from the sequencer to the ring of waiting teams.
    typedef struct packed {
        logic  push;
        team_t push_team;
        logic  pop;
        team_t pop_team;
    } ring_ctrl_t;

    // What the ring reports back.
    typedef struct packed {
        logic [ORD_CNT_W-1:0] count;
        team_t                head_team;
        logic [NUM_TEAMS-1:0] waiting;
    } ring_stat_t;

endpackage

// File: hw/rtl/tqm_in_if.sv
// Input channel: one command word per handshake.
interface tqm_in_if import tqm_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    member_t    member_id;
    team_t      team_number;

    modport source (output valid, output mode, output member_id, output team_number,
                    input ready);
    modport sink (input valid, input mode, input member_id, input team_number,
                  output ready);
endinterface

// File: hw/rtl/tqm_out_if.sv
// Output channel: one status word per handshake.
interface tqm_out_if import tqm_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] status;
    member_t    dequeued_member;

    modport source (output valid, output status, output dequeued_member, input ready);
    modport sink (input valid, input status, input dequeued_member, output ready);
endinterface

// File: hw/rtl/tqm_ram.sv
// Generic simple dual-port RAM with registered read data.
module tqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/tqm_order_ring.sv
// Ring of waiting teams in arrival order, with one waiting flag per team.
module tqm_order_ring import tqm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  ring_ctrl_t ctrl,
    output ring_stat_t stat
);

    team_t                order_reg [NUM_TEAMS];
    team_t                head_reg;
    team_t                tail_reg;
    logic [ORD_CNT_W-1:0] count_reg;
    logic [NUM_TEAMS-1:0] waiting_reg;

    // Slots hold payload only; head, tail and count guard every read.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            order_reg[tail_reg] <= ctrl.push_team;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            waiting_reg <= '0;
        end
        else
        begin
            if (ctrl.push)
            begin
                tail_reg                     <= tail_reg + 1'b1;
                waiting_reg[ctrl.push_team]  <= 1'b1;
            end
            if (ctrl.pop)
            begin
                head_reg                     <= head_reg + 1'b1;
                waiting_reg[ctrl.pop_team]   <= 1'b0;
            end
            if (ctrl.push && !ctrl.pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (ctrl.pop && !ctrl.push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign stat.count     = count_reg;
    assign stat.head_team = order_reg[head_reg];
    assign stat.waiting   = waiting_reg;

endmodule

// File: hw/rtl/team_queue_manager_core.sv
// Team queue manager: members join per-team FIFOs, teams are served in arrival order.
//
// After reset the block sweeps the member-to-team map to team 0, one entry a cycle,
// so the input stays not ready until all 1024 entries are written. After that the
// cycle in which a word is accepted issues the map read of an enqueue, and S_EXEC
// makes the decision, does the FIFO write of an enqueue and loads the result. A
// dequeue that returns a member goes on through S_POP for the FIFO store read; a
// dequeue on an empty queue loads its result from S_EXEC. A new word is accepted
// once the previous one has produced its result; a result waits in the output
// register while the next word is taken in, and a result that is still waiting holds
// the following word in its last cycle until the output register frees. Every
// accepted word gives exactly one status word.
module team_queue_manager_core import tqm_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    tqm_in_if.sink    req,
    tqm_out_if.source rsp
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_POP   = 2'd3;

    logic [1:0]    state_reg, state_next;
    member_t       clr_cnt_reg;
    logic [1:0]    mode_reg;
    member_t       member_reg;
    team_t         team_reg;

    logic [PTR_W-1:0] head_reg [NUM_TEAMS];
    logic [PTR_W-1:0] tail_reg [NUM_TEAMS];
    logic [CNT_W-1:0] fill_reg [NUM_TEAMS];

    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    member_t       out_member_reg;

    logic          accept;
    logic          slot_free;
    logic          out_load;
    logic [1:0]    out_status;
    member_t       out_member;

    logic          map_we, map_re;
    member_t       map_waddr;
    team_t         map_wdata;
    team_t         map_rdata;

    logic          fifo_we, fifo_re;
    logic [STORE_AW-1:0] fifo_waddr, fifo_raddr;
    member_t       fifo_rdata;

    logic          enq_upd, deq_upd;
    team_t         enq_team, deq_team;

    ring_ctrl_t    ring_ctrl;
    ring_stat_t    ring_stat;

    assign accept    = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign enq_team  = map_rdata;
    assign deq_team  = ring_stat.head_team;

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        out_load   = 1'b0;
        out_status = ST_DONE;
        out_member = '0;
        map_we     = 1'b0;
        map_waddr  = member_reg;
        map_wdata  = team_reg;
        map_re     = 1'b0;
        fifo_we    = 1'b0;
        fifo_waddr = {enq_team, tail_reg[enq_team]};
        fifo_re    = 1'b0;
        fifo_raddr = {deq_team, head_reg[deq_team]};
        enq_upd    = 1'b0;
        deq_upd    = 1'b0;
        ring_ctrl.push      = 1'b0;
        ring_ctrl.push_team = enq_team;
        ring_ctrl.pop       = 1'b0;
        ring_ctrl.pop_team  = deq_team;

        case (state_reg)
            S_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_cnt_reg;
                map_wdata = '0;
                if (&clr_cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                map_re    = req.valid && (req.mode == MODE_ENQUEUE);
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (mode_reg)
                    MODE_ASSIGN:
                    begin
                        if (slot_free)
                        begin
                            map_we     = 1'b1;
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    MODE_ENQUEUE:
                    begin
                        if (slot_free)
                        begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                            if (fill_reg[enq_team] == CNT_W'(TEAM_FIFO_DEPTH))
                            begin
                                out_status = ST_FULL;
                            end
                            else
                            begin
                                fifo_we = 1'b1;
                                enq_upd = 1'b1;
                                ring_ctrl.push = !ring_stat.waiting[enq_team] &&
                                    (ring_stat.count < ORD_CNT_W'(NUM_TEAMS));
                            end
                        end
                    end
                    MODE_DEQUEUE:
                    begin
                        if (ring_stat.count == '0)
                        begin
                            if (slot_free)
                            begin
                                out_load   = 1'b1;
                                out_status = ST_EMPTY;
                                state_next = S_IDLE;
                            end
                        end
                        else if (fill_reg[deq_team] != '0)
                        begin
                            // The member comes out of the registered store read in the next cycle, in S_POP.
                            fifo_re       = 1'b1;
                            deq_upd       = 1'b1;
                            ring_ctrl.pop = (fill_reg[deq_team] == CNT_W'(1));
                            state_next    = S_POP;
                        end
                        else if (slot_free)
                        begin
                            out_load      = 1'b1;
                            out_status    = ST_EMPTY;
                            ring_ctrl.pop = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (slot_free)
                        begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_POP:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    out_status = ST_POPPED;
                    out_member = fifo_rdata;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= req.mode;
            member_reg <= req.member_id;
            team_reg   <= req.team_number;
        end
        if (out_load)
        begin
            out_status_reg <= out_status;
            out_member_reg <= out_member;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TEAMS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            out_valid_reg <= out_load || (out_valid_reg && !rsp.ready);
            if (enq_upd)
            begin
                tail_reg[enq_team] <= tail_reg[enq_team] + 1'b1;
                fill_reg[enq_team] <= fill_reg[enq_team] + 1'b1;
            end
            if (deq_upd)
            begin
                head_reg[deq_team] <= head_reg[deq_team] + 1'b1;
                fill_reg[deq_team] <= fill_reg[deq_team] - 1'b1;
            end
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.dequeued_member = out_member_reg;

    tqm_ram #(
        .WIDTH (TEAM_W),
        .DEPTH (MEMBER_ID_SPACE)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (req.member_id),
        .rdata (map_rdata)
    );

    tqm_ram #(
        .WIDTH (MEMBER_W),
        .DEPTH (STORE_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (member_reg),
        .re    (fifo_re),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    tqm_order_ring u_order_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ring_ctrl),
        .stat  (ring_stat)
    );

endmodule
